// ===== hw/rtl/rtty_pkg.sv =====
package rtty_pkg;

    // default sample rate of the incoming offset stream
    localparam int unsigned SAMPLE_RATE_DEFAULT = 2000;

    // configuration register indexes
    localparam logic [2:0] REG_SYMBOL_LENGTH = 3'd0;
    localparam logic [2:0] REG_STOP_LENGTH   = 3'd1;
    localparam logic [2:0] REG_DATA_BITS     = 3'd2;
    localparam logic [2:0] REG_PARITY_MODE   = 3'd3;
    localparam logic [2:0] REG_MSB_FIRST     = 3'd4;
    localparam logic [2:0] REG_INVERT        = 3'd5;

    // configuration reset values
    localparam logic [11:0] SYMBOL_LENGTH_RST = 12'd44;
    localparam logic [12:0] STOP_LENGTH_RST   = 13'd44;
    localparam logic [3:0]  DATA_BITS_RST     = 4'd5;

    // parity modes; every code above always-zero means always-one
    localparam logic [2:0] PAR_NONE = 3'd0;
    localparam logic [2:0] PAR_ODD  = 3'd1;
    localparam logic [2:0] PAR_EVEN = 3'd2;
    localparam logic [2:0] PAR_ZERO = 3'd3;

    // result event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_CHAR    = 2'd1;
    localparam logic [1:0] EV_PARITY  = 2'd2;
    localparam logic [1:0] EV_FRAMING = 2'd3;

    // baud classes
    localparam logic [1:0] BAUD_45  = 2'd0;
    localparam logic [1:0] BAUD_50  = 2'd1;
    localparam logic [1:0] BAUD_75  = 2'd2;
    localparam logic [1:0] BAUD_100 = 2'd3;

    // baudot control codes
    localparam logic [4:0] BAUDOT_LTRS  = 5'h1F;
    localparam logic [4:0] BAUDOT_FIGS  = 5'h1B;
    localparam logic [4:0] BAUDOT_SPACE = 5'h04;

    localparam logic [14:0] RUN_MAX = 15'h7FFF;

    // bit reversal of a byte
    function automatic logic [7:0] rev8(input logic [7:0] d);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[7 - i] = d[i];
        end
        return r;
    endfunction

    // baudot letters case
    function automatic logic [7:0] baudot_letter(input logic [4:0] d);
        logic [7:0] c;
        case (d)
            5'd1:    c = "E";
            5'd2:    c = 8'h0A;
            5'd3:    c = "A";
            5'd4:    c = " ";
            5'd5:    c = "S";
            5'd6:    c = "I";
            5'd7:    c = "U";
            5'd8:    c = 8'h0D;
            5'd9:    c = "D";
            5'd10:   c = "R";
            5'd11:   c = "J";
            5'd12:   c = "N";
            5'd13:   c = "F";
            5'd14:   c = "C";
            5'd15:   c = "K";
            5'd16:   c = "T";
            5'd17:   c = "Z";
            5'd18:   c = "L";
            5'd19:   c = "W";
            5'd20:   c = "H";
            5'd21:   c = "Y";
            5'd22:   c = "P";
            5'd23:   c = "Q";
            5'd24:   c = "O";
            5'd25:   c = "B";
            5'd26:   c = "G";
            5'd28:   c = "M";
            5'd29:   c = "X";
            5'd30:   c = "V";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // baudot figures case
    function automatic logic [7:0] baudot_figure(input logic [4:0] d);
        logic [7:0] c;
        case (d)
            5'd1:    c = "3";
            5'd2:    c = 8'h0A;
            5'd3:    c = "-";
            5'd4:    c = " ";
            5'd5:    c = 8'h27;
            5'd6:    c = "8";
            5'd7:    c = "7";
            5'd8:    c = 8'h0D;
            5'd9:    c = "$";
            5'd10:   c = "4";
            5'd11:   c = 8'h07;
            5'd12:   c = ",";
            5'd13:   c = "!";
            5'd14:   c = ":";
            5'd15:   c = "(";
            5'd16:   c = "5";
            5'd17:   c = "+";
            5'd18:   c = ")";
            5'd19:   c = "2";
            5'd20:   c = "#";
            5'd21:   c = "6";
            5'd22:   c = "0";
            5'd23:   c = "1";
            5'd24:   c = "9";
            5'd25:   c = "?";
            5'd26:   c = "&";
            5'd28:   c = ".";
            5'd29:   c = "/";
            5'd30:   c = "=";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/rtty_character_receiver.sv =====
// RTTY character receiver. Takes one averaged frequency-offset sample per unstalled clock,
// slices it to a bit and runs an asynchronous start/data/parity/stop receiver on a sample
// counter, giving one result word per sample word. A sample passes the input register, then
// the state update into the result register. The receiver state advances once per sample,
// so consecutive samples never wait on each other. Five data bits select Baudot decoding
// with letters/figures shift; wider characters pass as raw bits. Baud class guesses come
// from run lengths compared against thresholds derived from SAMPLE_RATE at elaboration.
// The user must write configuration only while the block is idle; it is not enforced.
module rtty_character_receiver
    import rtty_pkg::*;
#(
    parameter int unsigned SAMPLE_RATE = SAMPLE_RATE_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [12:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] offset_sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         event_res,
    output logic [7:0]         char_code,
    output logic               bit_sampled,
    output logic               baud_valid,
    output logic [1:0]         baud_class
);

    // run length bounds for each baud class
    localparam int unsigned M_MIN    = SAMPLE_RATE / 1000;
    localparam int unsigned M45_LO   = SAMPLE_RATE / 48;
    localparam int unsigned M45_HI   = SAMPLE_RATE / 40;
    localparam int unsigned M50_LO   = SAMPLE_RATE / 56;
    localparam int unsigned M50_HI   = SAMPLE_RATE / 47;
    localparam int unsigned M75_LO   = SAMPLE_RATE / 86;
    localparam int unsigned M75_HI   = SAMPLE_RATE / 65;
    localparam int unsigned M100_LO  = SAMPLE_RATE / 111;
    localparam int unsigned M100_HI  = SAMPLE_RATE / 90;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_DATA   = 3'd2,
        PH_PARITY = 3'd3,
        PH_STOP   = 3'd4,
        PH_STOP2  = 3'd5
    } phase_t;

    // configuration
    logic [11:0] symbol_length_reg;
    logic [12:0] stop_length_reg;
    logic [3:0]  data_bits_reg;
    logic [2:0]  parity_mode_reg;
    logic        msb_first_reg;
    logic        invert_reg;

    // pipeline
    logic               in_valid_reg;
    logic signed [15:0] sample_reg;
    logic               out_valid_reg;
    logic [1:0]         event_reg;
    logic [7:0]         code_reg;
    logic               sampled_reg;
    logic               bvalid_reg;
    logic [1:0]         bclass_reg;
    logic               out_load;
    logic               in_load;
    logic               step;

    // receiver state
    phase_t      phase_reg, phase_next;
    logic [12:0] cnt_reg, cnt_next;
    logic [3:0]  idx_reg, idx_next;
    logic [8:0]  shift_reg, shift_next;
    logic        fig_reg, fig_next;
    logic        prev_reg, prev_next;
    logic [14:0] ones_reg, ones_next;
    logic [14:0] zeros_reg, zeros_next;

    // step results
    logic [1:0]  ev;
    logic [7:0]  code;
    logic        sampled;
    logic        bvalid;
    logic [1:0]  bclass;

    // helpers
    logic        bit_in;
    logic        neg;
    logic        pos;
    logic [12:0] cnt_dec;
    logic        cnt_zero;
    logic [12:0] half_sym;
    logic [3:0]  eff_bits;
    logic [7:0]  data_mask;
    logic [7:0]  data_raw;
    logic [7:0]  data_fin;
    logic        pbit;
    logic        want;
    logic        par_ok;
    logic [7:0]  baud_code;
    logic        baud_fig;
    logic [8:0]  shift_ins;
    logic [3:0]  idx_inc;
    logic [14:0] ones_inc;
    logic [14:0] zeros_inc;
    logic [14:0] run_max;
    logic        guess_ok;
    logic [1:0]  guess;

    // handshake
    assign out_load  = !out_valid_reg || !out_stall;
    assign in_load   = !in_valid_reg || out_load;
    assign in_stall  = !in_load;
    assign step      = in_valid_reg && out_load;
    assign out_valid = out_valid_reg;

    assign event_res   = event_reg;
    assign char_code   = code_reg;
    assign bit_sampled = sampled_reg;
    assign baud_valid  = bvalid_reg;
    assign baud_class  = bclass_reg;

    // slicer
    assign neg    = sample_reg[15];
    assign pos    = !neg && (sample_reg != 16'sd0);
    assign bit_in = invert_reg ? pos : neg;

    // counters
    assign cnt_dec  = cnt_reg - 13'd1;
    assign cnt_zero = (cnt_dec == 13'd0);
    assign half_sym = {2'b00, symbol_length_reg[11:1]};
    assign idx_inc  = idx_reg + 4'd1;

    // bit insert at the current index, nothing past the ninth bit
    always_comb
    begin
        shift_ins = shift_reg;
        for (int i = 0; i < 9; i++)
        begin
            if (idx_reg == 4'(i))
            begin
                shift_ins[i] = shift_reg[i] | bit_in;
            end
        end
    end

    // effective character width, parity check and bit order
    always_comb
    begin
        if (data_bits_reg < 4'd5)
        begin
            eff_bits = 4'd5;
        end
        else if (data_bits_reg > 4'd8)
        begin
            eff_bits = 4'd8;
        end
        else
        begin
            eff_bits = data_bits_reg;
        end
        case (eff_bits)
            4'd5:    data_mask = 8'h1F;
            4'd6:    data_mask = 8'h3F;
            4'd7:    data_mask = 8'h7F;
            default: data_mask = 8'hFF;
        endcase
        data_raw = shift_reg[7:0] & data_mask;
        pbit     = shift_reg[eff_bits];
        case (parity_mode_reg)
            PAR_ODD:  want = ^data_raw;
            PAR_EVEN: want = ~(^data_raw);
            PAR_ZERO: want = 1'b0;
            default:  want = 1'b1;
        endcase
        par_ok = (parity_mode_reg == PAR_NONE) || (pbit == want);
        data_fin = msb_first_reg ? (rev8(data_raw) >> (4'd8 - eff_bits)) : data_raw;
    end

    // baudot decode with shift state
    always_comb
    begin
        baud_fig = fig_reg;
        case (data_fin[4:0])
            BAUDOT_LTRS:
            begin
                baud_fig  = 1'b0;
                baud_code = 8'h00;
            end
            BAUDOT_FIGS:
            begin
                baud_fig  = 1'b1;
                baud_code = 8'h00;
            end
            BAUDOT_SPACE:
            begin
                baud_fig  = 1'b0;
                baud_code = " ";
            end
            default:
            begin
                baud_code = fig_reg ? baudot_figure(data_fin[4:0])
                                    : baudot_letter(data_fin[4:0]);
            end
        endcase
    end

    // run lengths and baud class guess
    always_comb
    begin
        ones_inc  = (ones_reg == RUN_MAX) ? ones_reg : ones_reg + 15'd1;
        zeros_inc = (zeros_reg == RUN_MAX) ? zeros_reg : zeros_reg + 15'd1;
        if (bit_in)
        begin
            run_max = (zeros_reg > ones_inc) ? zeros_reg : ones_inc;
        end
        else
        begin
            run_max = (zeros_inc > ones_reg) ? zeros_inc : ones_reg;
        end
        guess_ok = 1'b1;
        guess    = BAUD_45;
        if (run_max == 15'd0 || 32'(run_max) < M_MIN)
        begin
            guess_ok = 1'b0;
        end
        else if (32'(run_max) > M45_LO && 32'(run_max) <= M45_HI)
        begin
            guess = BAUD_45;
        end
        else if (32'(run_max) > M50_LO && 32'(run_max) <= M50_HI)
        begin
            guess = BAUD_50;
        end
        else if (32'(run_max) > M75_LO && 32'(run_max) <= M75_HI)
        begin
            guess = BAUD_75;
        end
        else if (32'(run_max) > M100_LO && 32'(run_max) <= M100_HI)
        begin
            guess = BAUD_100;
        end
        else
        begin
            guess_ok = 1'b0;
        end
    end

    // receiver state update for one sample
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        shift_next = shift_reg;
        fig_next   = fig_reg;
        prev_next  = prev_reg;
        ones_next  = ones_reg;
        zeros_next = zeros_reg;
        ev         = EV_NONE;
        code       = 8'h00;
        sampled    = 1'b0;
        bvalid     = 1'b0;
        bclass     = BAUD_45;
        case (phase_reg)
            PH_IDLE:
            begin
                if (!bit_in)
                begin
                    phase_next = PH_START;
                    cnt_next   = half_sym;
                end
            end
            PH_START:
            begin
                cnt_next = cnt_dec;
                if (cnt_zero)
                begin
                    if (!bit_in)
                    begin
                        cnt_next   = {1'b0, symbol_length_reg};
                        idx_next   = 4'd0;
                        shift_next = 9'd0;
                        sampled    = 1'b1;
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_DATA:
            begin
                if (cnt_reg <= 13'd1)
                begin
                    shift_next = shift_ins;
                    idx_next   = idx_inc;
                    cnt_next   = {1'b0, symbol_length_reg};
                    sampled    = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_dec;
                end
                if (bit_in)
                begin
                    ones_next = ones_inc;
                end
                else
                begin
                    zeros_next = zeros_inc;
                end
                if (bit_in != prev_reg)
                begin
                    bvalid     = guess_ok;
                    bclass     = guess_ok ? guess : BAUD_45;
                    ones_next  = 15'd0;
                    zeros_next = 15'd0;
                end
                prev_next = bit_in;
                if (idx_next >= eff_bits)
                begin
                    sampled    = 1'b1;
                    phase_next = (parity_mode_reg == PAR_NONE) ? PH_STOP : PH_PARITY;
                end
            end
            PH_PARITY:
            begin
                cnt_next = cnt_dec;
                if (cnt_zero)
                begin
                    phase_next = PH_STOP;
                    shift_next = shift_ins;
                    idx_next   = idx_inc;
                    cnt_next   = stop_length_reg;
                end
            end
            PH_STOP:
            begin
                cnt_next = cnt_dec;
                if (cnt_zero)
                begin
                    if (bit_in)
                    begin
                        if (!par_ok)
                        begin
                            ev = EV_PARITY;
                        end
                        else if (eff_bits == 4'd5)
                        begin
                            ev       = EV_CHAR;
                            code     = baud_code;
                            fig_next = baud_fig;
                        end
                        else
                        begin
                            ev   = EV_CHAR;
                            code = data_fin;
                        end
                    end
                    else
                    begin
                        ev = EV_FRAMING;
                    end
                    phase_next = PH_STOP2;
                    cnt_next   = half_sym;
                end
            end
            PH_STOP2:
            begin
                cnt_next = cnt_dec;
                if (cnt_zero)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_length_reg <= SYMBOL_LENGTH_RST;
            stop_length_reg   <= STOP_LENGTH_RST;
            data_bits_reg     <= DATA_BITS_RST;
            parity_mode_reg   <= PAR_NONE;
            msb_first_reg     <= 1'b0;
            invert_reg        <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SYMBOL_LENGTH: symbol_length_reg <= cfg_data[11:0];
                REG_STOP_LENGTH:   stop_length_reg   <= cfg_data;
                REG_DATA_BITS:     data_bits_reg     <= cfg_data[3:0];
                REG_PARITY_MODE:   parity_mode_reg   <= cfg_data[2:0];
                REG_MSB_FIRST:     msb_first_reg     <= cfg_data[0];
                REG_INVERT:        invert_reg        <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && in_valid)
        begin
            sample_reg <= offset_sample;
        end
    end

    // receiver state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= 13'd0;
            idx_reg       <= 4'd0;
            shift_reg     <= 9'd0;
            fig_reg       <= 1'b0;
            prev_reg      <= 1'b0;
            ones_reg      <= 15'd0;
            zeros_reg     <= 15'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                idx_reg   <= idx_next;
                shift_reg <= shift_next;
                fig_reg   <= fig_next;
                prev_reg  <= prev_next;
                ones_reg  <= ones_next;
                zeros_reg <= zeros_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            event_reg   <= ev;
            code_reg    <= code;
            sampled_reg <= sampled;
            bvalid_reg  <= bvalid;
            bclass_reg  <= bclass;
        end
    end

endmodule

// ===== hw/rtl/rtty_checker.sv =====
module rtty_checker
    import rtty_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_we,
    input logic [2:0]         cfg_index,
    input logic [12:0]        cfg_data,
    input logic               in_valid,
    input logic               in_stall,
    input logic signed [15:0] offset_sample,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         event_res,
    input logic [7:0]         char_code,
    input logic               bit_sampled,
    input logic               baud_valid,
    input logic [1:0]         baud_class
);

    // input backs up only behind a stalled, occupied output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output free");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(event_res)
            && $stable(char_code) && $stable(bit_sampled) && $stable(baud_valid)
            && $stable(baud_class)))
        else $error("stalled result word changed");

    // code is zero unless a character is reported
    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res != EV_CHAR) |-> (char_code == 8'h00))
        else $error("char_code set without character event");

    // stop-bit events never coincide with data-phase flags
    a_event_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res != EV_NONE) |-> (!bit_sampled && !baud_valid))
        else $error("event reported during data phase");

    // baud class is zero when no guess is reported
    a_class_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !baud_valid) |-> (baud_class == BAUD_45))
        else $error("baud_class set without baud_valid");

endmodule

bind rtty_character_receiver rtty_checker u_rtty_checker (.*);
